@@ rtl/sorted_table_equal_range_search_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_assert.svh
// Assertion macros shared by the key table search RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_EQUAL_RANGE_SEARCH_ASSERT_SVH
`define SORTED_TABLE_EQUAL_RANGE_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STERS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STERS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sters_pkg.sv @@
// ----------------------------------------------------------------------------
// sters_pkg
// Status codes, register indexes and widths of the key table search block.
// ----------------------------------------------------------------------------
package sters_pkg;

    localparam int KEY_W   = 32;
    localparam int CNT_W   = 11;
    localparam int IDX_W   = 11;
    // internal signed index width: holds -1 .. 1024
    localparam int POS_W   = 12;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_WINDOW = 2'd2;
    localparam logic [1:0] ST_NOT_SORTED = 2'd3;

    localparam logic CFG_ENTRY_COUNT  = 1'b0;
    localparam logic CFG_TABLE_SORTED = 1'b1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [IDX_W-1:0] IDX_NONE_LO = 11'h7FF;   // -1
    localparam logic [IDX_W-1:0] IDX_NONE_HI = 11'h7FE;   // -2

endpackage

@@ rtl/sorted_table_equal_range_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search
// Sorted key table with binary search and equal-range walk.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a word with cmd 0 stores id_value at
// write_index and gives no result; cmd 1 searches for id_value inside the
// window from_index .. upto_index (negative upto means last valid entry).
// Output channel (out_valid / out_stall): one word per search with status,
// lower_index and upper_index (-1 / -2 unless found).
// Config channel (cfg_valid / cfg_ready): index 0 entry_count, index 1
// table_sorted; always ready, write only while idle.
// One single-port key memory with a registered read sets the pace.
// A write is stored as it is accepted. A search that fails a check goes
// straight to the done state; otherwise each binary probe passes the probe
// and compare states, and on a hit each extra equal key on each side passes
// a walk and a compare state before the done state loads the result.
// At most ceil(log2(window + 1)) probes are made. One search is in flight
// at a time.
// A finished result is held in the output register; while it is stalled the
// block still accepts the next word, and a new result waits in the done
// state until the register frees. Reset clears control state and registers;
// the key memory is not cleared and must be written before it is searched.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 cmd,
    input  logic [9:0]           write_index,
    input  logic signed [31:0]   id_value,
    input  logic [9:0]           from_index,
    input  logic signed [10:0]   upto_index,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic signed [10:0]   lower_index,
    output logic signed [10:0]   upper_index,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [10:0]          cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = sters_pkg::POS_W;
    localparam logic [sters_pkg::CNT_W-1:0] DEPTH_CNT = TABLE_DEPTH[sters_pkg::CNT_W-1:0];

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_WALK_DN,
        S_DN_CMP,
        S_WALK_UP,
        S_UP_CMP,
        S_DONE
    } state_t;

    logic signed [sters_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];

    state_t                     state_reg, state_next;
    logic [sters_pkg::CNT_W-1:0] count_reg;
    logic                       sorted_reg;
    logic signed [31:0]         key_reg, key_next;
    logic signed [PW-1:0]       low_reg, low_next;
    logic signed [PW-1:0]       up_reg, up_next;
    logic signed [PW-1:0]       mid_reg, mid_next;
    logic signed [PW-1:0]       lo_reg, lo_next;
    logic signed [PW-1:0]       hi_reg, hi_next;
    logic [1:0]                 res_st_reg, res_st_next;
    logic [10:0]                res_lo_reg, res_lo_next;
    logic [10:0]                res_hi_reg, res_hi_next;
    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 out_st_reg, out_st_next;
    logic [10:0]                out_lo_reg, out_lo_next;
    logic [10:0]                out_hi_reg, out_hi_next;
    logic signed [31:0]         rd_data_reg;

    logic                       in_acc;
    logic                       mem_we;
    logic [AW-1:0]              wr_addr;
    logic [AW+9:0]              wr_wide;
    logic                       rd_en;
    logic signed [PW-1:0]       rd_pos;
    logic [AW+PW-1:0]           rd_wide;
    logic [AW-1:0]              rd_addr;

    logic [sters_pkg::CNT_W-1:0] n_sat;
    logic signed [PW-1:0]       n_pos, from_pos, upto_pos;
    logic signed [PW-1:0]       span, probe_pos, nlow, nup;
    logic                       key_eq, key_gt;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign lower_index = out_lo_reg;
    assign upper_index = out_hi_reg;

    // window setup
    assign n_sat    = (32'(count_reg) > TABLE_DEPTH) ? DEPTH_CNT : count_reg;
    assign n_pos    = {1'b0, n_sat};
    assign from_pos = {2'b00, from_index};
    assign upto_pos = upto_index[10] ? (n_pos - 12'sd1) : {2'b00, upto_index[9:0]};

    // probe point and compare against the word read last cycle
    assign span      = up_reg - low_reg;
    assign probe_pos = low_reg + (span >>> 1);
    assign key_eq    = (key_reg == rd_data_reg);
    assign key_gt    = (key_reg > rd_data_reg);
    assign nlow      = key_gt ? mid_reg : low_reg;
    assign nup       = key_gt ? up_reg : mid_reg;

    assign wr_wide = {{AW{1'b0}}, write_index};
    assign wr_addr = wr_wide[AW-1:0];
    assign mem_we  = in_acc && (cmd == sters_pkg::CMD_WRITE)
                     && (32'(write_index) < TABLE_DEPTH);

    assign rd_wide = {{AW{1'b0}}, rd_pos};
    assign rd_addr = rd_wide[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        low_next       = low_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_st_next    = res_st_reg;
        res_lo_next    = res_lo_reg;
        res_hi_next    = res_hi_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_st_next    = out_st_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        rd_en          = 1'b0;
        rd_pos         = probe_pos;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (cmd == sters_pkg::CMD_SEARCH))
                begin
                    key_next    = id_value;
                    low_next    = from_pos - 12'sd1;
                    up_next     = upto_pos + 12'sd1;
                    res_lo_next = sters_pkg::IDX_NONE_LO;
                    res_hi_next = sters_pkg::IDX_NONE_HI;
                    if (!sorted_reg)
                    begin
                        res_st_next = sters_pkg::ST_NOT_SORTED;
                        state_next  = S_DONE;
                    end
                    else if (n_sat == '0)
                    begin
                        res_st_next = sters_pkg::ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else if ((upto_pos >= n_pos) || (from_pos > upto_pos))
                    begin
                        res_st_next = sters_pkg::ST_BAD_WINDOW;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                rd_en      = 1'b1;
                rd_pos     = probe_pos;
                mid_next   = probe_pos;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_eq)
                begin
                    lo_next    = mid_reg;
                    hi_next    = mid_reg;
                    state_next = S_WALK_DN;
                end
                else
                begin
                    low_next = nlow;
                    up_next  = nup;
                    if ((nup - nlow) > 12'sd1)
                    begin
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        res_st_next = sters_pkg::ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
            end
            S_WALK_DN:
            begin
                rd_pos = lo_reg - 12'sd1;
                if (lo_reg > (low_reg + 12'sd1))
                begin
                    rd_en      = 1'b1;
                    state_next = S_DN_CMP;
                end
                else
                begin
                    state_next = S_WALK_UP;
                end
            end
            S_DN_CMP:
            begin
                if (key_eq)
                begin
                    lo_next    = lo_reg - 12'sd1;
                    state_next = S_WALK_DN;
                end
                else
                begin
                    state_next = S_WALK_UP;
                end
            end
            S_WALK_UP:
            begin
                rd_pos = hi_reg + 12'sd1;
                if (hi_reg < (up_reg - 12'sd1))
                begin
                    rd_en      = 1'b1;
                    state_next = S_UP_CMP;
                end
                else
                begin
                    res_st_next = sters_pkg::ST_FOUND;
                    res_lo_next = lo_reg[10:0];
                    res_hi_next = hi_reg[10:0];
                    state_next  = S_DONE;
                end
            end
            S_UP_CMP:
            begin
                if (key_eq)
                begin
                    hi_next    = hi_reg + 12'sd1;
                    state_next = S_WALK_UP;
                end
                else
                begin
                    res_st_next = sters_pkg::ST_FOUND;
                    res_lo_next = lo_reg[10:0];
                    res_hi_next = hi_reg[10:0];
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register frees
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_lo_next    = res_lo_reg;
                    out_hi_next    = res_hi_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sorted_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sters_pkg::CFG_ENTRY_COUNT)
                begin
                    count_reg <= cfg_data;
                end
                else
                begin
                    sorted_reg <= cfg_data[0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        low_reg    <= low_next;
        up_reg     <= up_next;
        mid_reg    <= mid_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        res_st_reg <= res_st_next;
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
        out_st_reg <= out_st_next;
        out_lo_reg <= out_lo_next;
        out_hi_reg <= out_hi_next;
    end

    // key memory: writes only while idle, reads only while searching
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= id_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

`include "sorted_table_equal_range_search_assert.svh"

    `STERS_ASSERT_NOW(a_probe_inside, state_reg == S_CMP, (low_reg < mid_reg) && (mid_reg < up_reg), "probe outside search bounds")
    `STERS_ASSERT_NOW(a_found_order, out_valid && (status == sters_pkg::ST_FOUND), lower_index <= upper_index, "found range reversed")
    `STERS_ASSERT_NOW(a_miss_marks, out_valid && (status != sters_pkg::ST_FOUND), (lower_index == -11'sd1) && (upper_index == -11'sd2), "miss without index marks")
    `STERS_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (cmd == sters_pkg::CMD_SEARCH), state_reg != S_IDLE, "search word dropped")

endmodule

@@ test/sorted_table_equal_range_search_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_equal_range_search_tb
// Self-checking bench for the sorted key table search block.
// Loads key tables of many shapes (dense runs of equal keys, wide spread,
// all equal, unsorted leftovers), programs count and sorted flag between
// phases, and fires searches with hit, miss, negative and bad windows.
// A scoreboard mirrors the key table and registers, predicts each search
// answer with the same probe order, and checks every output word in order.
// ----------------------------------------------------------------------------
module sorted_table_equal_range_search_tb;

    localparam int TABLE_DEPTH   = 1024;
    localparam int ITEM_TARGET   = 1850;
    localparam int CYCLE_LIMIT   = 20000000;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [1:0]                         status;
        logic signed [sters_pkg::IDX_W-1:0] lower;
        logic signed [sters_pkg::IDX_W-1:0] upper;
    } answer_t;

    typedef enum {FILL_DENSE, FILL_WIDE, FILL_FLAT} fill_mode_t;

    class search_scoreboard;
        logic signed [sters_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
        logic [sters_pkg::CNT_W-1:0]        entry_count;
        logic                               table_sorted;
        answer_t                            pending [$];
        int                                 mismatches;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                keys[i] = '0;
            end
            entry_count  = '0;
            table_sorted = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_register(logic idx, logic [sters_pkg::CNT_W-1:0] data);
            if (idx == sters_pkg::CFG_ENTRY_COUNT)
                entry_count = data;
            else
                table_sorted = data[0];
        endfunction

        function answer_t predict_search(logic signed [sters_pkg::KEY_W-1:0] key,
                                         logic [9:0] from_idx,
                                         logic signed [sters_pkg::IDX_W-1:0] upto_idx);
            answer_t a;
            int      n;
            int      first;
            int      last;
            int      lo_b;
            int      hi_b;
            int      probe;
            int      hit;
            a.status = sters_pkg::ST_NOT_FOUND;
            a.lower  = sters_pkg::IDX_NONE_LO;
            a.upper  = sters_pkg::IDX_NONE_HI;
            if (!table_sorted)
            begin
                a.status = sters_pkg::ST_NOT_SORTED;
                return a;
            end
            n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
            if (n == 0)
                return a;
            first = int'(from_idx);
            last  = upto_idx[sters_pkg::IDX_W-1] ? n - 1 : int'(upto_idx[9:0]);
            if (last >= n || first > last)
            begin
                a.status = sters_pkg::ST_BAD_WINDOW;
                return a;
            end
            lo_b = first - 1;
            hi_b = last + 1;
            hit  = -1;
            while (hi_b - lo_b > 1)
            begin
                probe = lo_b + (hi_b - lo_b) / 2;
                if (keys[probe] == key)
                begin
                    hit = probe;
                    break;
                end
                else if (key > keys[probe])
                    lo_b = probe;
                else
                    hi_b = probe;
            end
            if (hit < 0)
                return a;
            // walk outward, bounded by the probe bounds at the hit
            first = hit;
            last  = hit;
            while (first > lo_b + 1 && keys[first-1] == key)
                first--;
            while (last < hi_b - 1 && keys[last+1] == key)
                last++;
            a.status = sters_pkg::ST_FOUND;
            a.lower  = first[sters_pkg::IDX_W-1:0];
            a.upper  = last[sters_pkg::IDX_W-1:0];
            return a;
        endfunction

        function void note_word(logic c, logic [9:0] widx,
                                logic signed [sters_pkg::KEY_W-1:0] val,
                                logic [9:0] from_idx,
                                logic signed [sters_pkg::IDX_W-1:0] upto_idx);
            if (c == sters_pkg::CMD_WRITE)
                keys[widx] = val;
            else
                pending.push_back(predict_search(val, from_idx, upto_idx));
        endfunction

        function void check_answer(logic [1:0] st, logic signed [sters_pkg::IDX_W-1:0] lo,
                                   logic signed [sters_pkg::IDX_W-1:0] up);
            answer_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected search word: status %0d lower %0d upper %0d",
                             st, lo, up);
                return;
            end
            want = pending.pop_front();
            if (st !== want.status || lo !== want.lower || up !== want.upper)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("search mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             want.status, want.lower, want.upper, st, lo, up);
            end
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic                               cmd;
    logic [9:0]                         write_index;
    logic signed [sters_pkg::KEY_W-1:0] id_value;
    logic [9:0]                         from_index;
    logic signed [sters_pkg::IDX_W-1:0] upto_index;
    logic                               out_valid;
    logic                               out_stall;
    logic [1:0]                         status;
    logic signed [sters_pkg::IDX_W-1:0] lower_index;
    logic signed [sters_pkg::IDX_W-1:0] upper_index;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic                               cfg_index;
    logic [sters_pkg::CNT_W-1:0]        cfg_data;

    search_scoreboard board;
    int               items_sent;
    bit               calm;
    longint           cycles = 0;

    sorted_table_equal_range_search #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .write_index(write_index),
        .id_value   (id_value),
        .from_index (from_index),
        .upto_index (upto_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .lower_index(lower_index),
        .upper_index(upper_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: hold stall for a drawn number of cycles per word
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 7);
            out_stall = (hold != 0);
            repeat (hold) @(negedge clk);
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            board.check_answer(status, lower_index, upper_index);
            @(negedge clk);
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_word(logic c, logic [9:0] widx, logic signed [sters_pkg::KEY_W-1:0] val,
                             logic [9:0] from_idx,
                             logic signed [sters_pkg::IDX_W-1:0] upto_idx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        cmd         = c;
        write_index = widx;
        id_value    = val;
        from_index  = from_idx;
        upto_index  = upto_idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_word(c, widx, val, from_idx, upto_idx);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_write(logic [9:0] widx, logic signed [sters_pkg::KEY_W-1:0] val);
        send_word(sters_pkg::CMD_WRITE, widx, val, 10'($urandom), 11'($urandom));
    endtask

    task automatic send_search(logic signed [sters_pkg::KEY_W-1:0] key, logic [9:0] from_idx,
                               logic signed [sters_pkg::IDX_W-1:0] upto_idx);
        send_word(sters_pkg::CMD_SEARCH, 10'($urandom), key, from_idx, upto_idx);
    endtask

    // drop valid, wait for every answer, then let trailing writes settle
    task automatic drain();
        in_valid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_regs(logic [sters_pkg::CNT_W-1:0] count_val,
                                logic [sters_pkg::CNT_W-1:0] sorted_val);
        cfg_valid = 1'b1;
        cfg_index = sters_pkg::CFG_ENTRY_COUNT;
        cfg_data  = count_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(sters_pkg::CFG_ENTRY_COUNT, count_val);
        @(negedge clk);
        cfg_index = sters_pkg::CFG_TABLE_SORTED;
        cfg_data  = sorted_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(sters_pkg::CFG_TABLE_SORTED, sorted_val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_table(int n, fill_mode_t mode);
        longint v;
        longint stride;
        stride = 64'sd4294967296 / (n + 1);
        case (mode)
            FILL_DENSE: v = longint'($urandom_range(0, 40)) - 20;
            FILL_WIDE:  v = -64'sd2147483648 +
                            ($urandom_range(0, 1) ? 0 : longint'($urandom_range(0, 1000)));
            default:    v = longint'(signed'($urandom));
        endcase
        for (int i = 0; i < n; i++)
        begin
            if (mode == FILL_WIDE && i == n - 1 && $urandom_range(0, 1))
                v = 64'sd2147483647;
            send_write(10'(i), 32'(v));
            if (mode == FILL_DENSE)
                v += $urandom_range(0, 2);
            else if (mode == FILL_WIDE && $urandom_range(0, 7) != 0)
                v += longint'($urandom_range(0, 32'(stride)));
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
        end
    endtask

    task automatic run_searches(int count);
        int                                 ne;
        int                                 f;
        int                                 u;
        int                                 last;
        int                                 idx;
        int                                 r;
        logic signed [sters_pkg::KEY_W-1:0] key;
        ne = (board.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(board.entry_count);
        for (int k = 0; k < count; k++)
        begin
            // stray table write, sometimes copying a neighbor to grow a run
            if ($urandom_range(0, 7) == 0)
            begin
                idx = $urandom_range(0, TABLE_DEPTH - 1);
                if (idx > 0 && $urandom_range(0, 1))
                    key = board.keys[idx-1];
                else
                    key = $urandom;
                send_write(10'(idx), key);
                continue;
            end
            if (ne == 0)
            begin
                send_search($urandom, 10'($urandom), 11'($urandom));
                continue;
            end
            r = $urandom_range(0, 9);
            if (r <= 6)
            begin
                f = $urandom_range(0, ne - 1);
                u = $urandom_range(f, ne - 1);
            end
            else if (r == 7)
            begin
                f = $urandom_range(0, ne - 1);
                u = $urandom_range(0, 1) ? -1 : -int'($urandom_range(1, 1024));
            end
            else
            begin
                f = $urandom_range(0, 1023);
                u = int'($urandom_range(0, 2047)) - (($urandom_range(0, 1)) ? 2048 : 0);
            end
            last = (11'(u) >> 10) ? ne - 1 : int'(u[9:0]);
            if (last < ne && f <= last)
                idx = $urandom_range(f, last);
            else
                idx = $urandom_range(0, ne - 1);
            case ($urandom_range(0, 9))
                6:       key = board.keys[idx] + 1;
                7:       key = $urandom;
                8:       key = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                9:       key = board.keys[idx] - 1;
                default: key = board.keys[idx];
            endcase
            send_search(key, 10'(f), 11'(u));
        end
    endtask

    initial
    begin
        int         kind;
        int         n;
        int         phase_no;
        fill_mode_t mode;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = sters_pkg::CMD_WRITE;
        write_index = '0;
        id_value    = '0;
        from_index  = '0;
        upto_index  = '0;
        cfg_valid   = 1'b0;
        cfg_index   = sters_pkg::CFG_ENTRY_COUNT;
        cfg_data    = '0;
        calm        = 1'b0;
        items_sent  = 0;
        board       = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // out of reset the table is not declared sorted
        send_search(32'sd0, 10'd0, -11'sd1);
        drain();
        // sorted but empty: not found wins over a bad window
        program_regs(11'd0, 11'd1);
        send_search(32'sd5, 10'd0, -11'sd1);
        send_search(32'sd5, 10'd7, 11'sd3);
        send_write(10'd0, 32'sh8000_0000);
        send_write(10'd1, 32'sh8000_0000);
        send_write(10'd2, -32'sd5);
        send_write(10'd3, 32'sd0);
        send_write(10'd4, 32'sd0);
        send_write(10'd5, 32'sd0);
        send_write(10'd6, 32'sd7);
        send_write(10'd7, 32'sh7FFF_FFFF);
        send_write(10'd1023, 32'sh7FFF_FFFF);
        drain();
        program_regs(11'd8, 11'd1);
        send_search(32'sd0, 10'd0, -11'sd1);
        send_search(32'sh8000_0000, 10'd0, 11'sd7);
        send_search(32'sh7FFF_FFFF, 10'd0, -11'sd1);
        send_search(32'sd1, 10'd0, -11'sd1);
        // run of zeros clipped by the window
        send_search(32'sd0, 10'd4, 11'sd4);
        send_search(32'sd0, 10'd5, 11'sd3);
        send_search(32'sd0, 10'd0, 11'sd8);
        send_search(32'sd7, 10'd2, -11'sd1024);
        send_search(32'sd7, 10'd1023, -11'sd1);
        drain();

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            kind = (phase_no == 0) ? -1 : $urandom_range(0, 9);
            calm = ($urandom_range(0, 3) == 0);
            case (kind)
                -1:
                begin
                    // fill the whole table once so any count is safe afterward
                    load_table(TABLE_DEPTH, FILL_WIDE);
                    drain();
                    program_regs(11'd1024, 11'd1);
                    run_searches(60);
                end
                0:
                begin
                    program_regs(11'($urandom_range(0, 2047)), {10'($urandom), 1'b0});
                    run_searches(8);
                end
                1:
                begin
                    program_regs(11'd0, {10'($urandom), 1'b1});
                    run_searches(8);
                end
                2:
                begin
                    case ($urandom_range(0, 2))
                        0:       n = 1023;
                        1:       n = 1024;
                        default: n = 2047;
                    endcase
                    program_regs(11'(n), {10'($urandom), 1'b1});
                    run_searches(60);
                end
                default:
                begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 200);
                    mode = fill_mode_t'($urandom_range(0, 2));
                    load_table(n, mode);
                    drain();
                    program_regs(11'(n), $urandom_range(0, 1) ? 11'd1 : {10'($urandom), 1'b1});
                    run_searches(60);
                end
            endcase
            drain();
            phase_no++;
        end

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
